FILE: hdl/rv32_pkg.sv
`default_nettype none
package rv32_pkg;
    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW = $clog2(MEM_BYTES);
    localparam int MEM_WORDS = MEM_BYTES / 4;
    localparam int WORD_AW = MEM_AW - 2;
    localparam int CLR_W = WORD_AW + 1;

    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [6:0] F7_ALT = 7'h20;
    localparam logic [6:0] F7_BASE = 7'h00;

    localparam logic [2:0] F3_MUL = 3'd0, F3_MULH = 3'd1, F3_MULHSU = 3'd2,
                           F3_MULHU = 3'd3, F3_DIV = 3'd4, F3_DIVU = 3'd5,
                           F3_REM = 3'd6, F3_REMU = 3'd7;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_EXEC  = 7'b0001000,
        ST_MDIV  = 7'b0010000,
        ST_MEM   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;
endpackage
`default_nettype wire

FILE: hdl/rv32im_instruction_executor_top.sv
// RV32IM instruction executor.
// Input channel s_axis: one 32-bit instruction word per word transfer.
// Output channel m_axis: one result word per instruction, carrying the
// register write, destination, written value, next pc and the branch,
// ECALL and EBREAK flags.
// The register file and the data memory are synchronous RAMs with a
// registered read port. ALU, branch, jump and system words pass through
// the execute and output states before the result is registered.
// Loads do one read and stores one read-modify-write of the word-wide
// memory, and two when the access straddles a word boundary.
// Multiply, divide and remainder run one shift-add or restoring step per
// cycle, 32 steps in all. The next word can be accepted as soon as the
// result is registered; no new word is taken while one is in flight.
// After reset the block clears the data memory, one word per cycle;
// s_axis_tready stays low until the clear is done.
// The pc and registers reset to zero. A result waits in the output
// register while m_axis_tready is low; the next word may still be accepted
// and executed, but it stops before its register write until that
// register has been emptied.
`default_nettype none
module rv32im_instruction_executor_top
    import rv32_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [31:0] instruction_word
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] reg_write, [5:1] dest_reg, [37:6] write_value, [69:38] next_pc,
    // [70] branch_taken, [71] env_call, [72] env_break, [79:73] zero
    output logic [79:0]      m_axis_tdata
);
    state_t state_reg, state_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic [31:0] ir_reg, ir_next;
    logic [31:0] pc_reg, pc_next;
    logic [79:0] out_reg, out_next;
    logic [5:0] cnt_reg, cnt_next;
    logic phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] dd_reg, dd_next;
    logic [31:0] val_reg, val_next;
    logic [31:0] npc_reg, npc_next;
    logic wr_reg, wr_next, br_reg, br_next;
    logic [MEM_AW-1:0] ad_reg, ad_next;
    logic ovalid_reg, ovalid_next;
    logic out_busy;

    // Register file RAM.
    logic [31:0] rf_mem [32];
    logic [31:0] ra_q, rb_q;
    logic rf_we;
    logic [4:0] rf_wa;
    logic [31:0] rf_wd;
    logic [4:0] rs1_rd, rs2_rd;

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_wa] <= rf_wd;
        end
        ra_q <= rf_mem[rs1_rd];
        rb_q <= rf_mem[rs2_rd];
    end

    // Registers are not cleared in RAM: a written flag per entry stands in.
    logic [31:0] rfv_reg, rfv_next;
    logic rs1v_reg, rs2v_reg;
    logic [31:0] a, b;
    assign a = rs1v_reg ? ra_q : 32'd0;
    assign b = rs2v_reg ? rb_q : 32'd0;

    // Data memory, word wide with byte lanes.
    logic [31:0] dm_mem [MEM_WORDS];
    logic [31:0] dm_q;
    logic dm_we;
    logic [WORD_AW-1:0] dm_wa, dm_ra;
    logic [31:0] dm_wd;

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dm_mem[dm_wa] <= dm_wd;
        end
        dm_q <= dm_mem[dm_ra];
    end

    // Instruction fields.
    logic [6:0] op, f7;
    logic [4:0] rd;
    logic [2:0] f3;
    logic [31:0] sgn, iimm, simm, bimm, jimm, uimm;
    assign op = ir_reg[6:0];
    assign rd = ir_reg[11:7];
    assign f3 = ir_reg[14:12];
    assign f7 = ir_reg[31:25];
    assign sgn = {32{ir_reg[31]}};
    assign iimm = {sgn[19:0], ir_reg[31:20]};
    assign simm = {sgn[19:0], ir_reg[31:25], ir_reg[11:7]};
    assign bimm = {sgn[18:0], ir_reg[31], ir_reg[7], ir_reg[30:25], ir_reg[11:8], 1'b0};
    assign jimm = {sgn[10:0], ir_reg[31], ir_reg[19:12], ir_reg[20], ir_reg[30:21], 1'b0};
    assign uimm = {ir_reg[31:12], 12'd0};

    // Byte position handling for memory access.
    logic [1:0] boff;
    logic [2:0] nbytes;
    logic [6:0] lane_hi;
    logic [63:0] sdata_sh, smask_sh;
    logic [63:0] ld_cat;
    logic [WORD_AW-1:0] wa0, wa1;
    assign boff = ad_reg[1:0];
    assign wa0 = ad_reg[MEM_AW-1:2];
    assign wa1 = wa0 + WORD_AW'(1);
    assign nbytes = (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4;
    assign lane_hi = {5'd0, boff} + {4'd0, nbytes};
    assign sdata_sh = {32'd0, b} << {boff, 3'b000};
    assign smask_sh = ({32'd0, (nbytes == 3'd1) ? 32'h000000ff :
                       (nbytes == 3'd2) ? 32'h0000ffff : 32'hffffffff})
                      << {boff, 3'b000};
    assign ld_cat = {dd_reg, acc_reg[31:0]};

    // Signed / unsigned operand conditioning for mul and div.
    logic a_neg, b_neg;
    logic [31:0] abs_a, abs_b;
    assign a_neg = a[31] && (f3 == F3_MULH || f3 == F3_MULHSU || f3 == F3_DIV || f3 == F3_REM);
    assign b_neg = b[31] && (f3 == F3_MULH || f3 == F3_DIV || f3 == F3_REM);
    assign abs_a = a_neg ? (32'd0 - a) : a;
    assign abs_b = b_neg ? (32'd0 - b) : b;
    logic neg_res_reg, neg_res_next;
    logic [31:0] dvs_reg, dvs_next;

    // The shifted partial remainder is 33 bits wide.
    logic [32:0] rem_try;
    assign rem_try = acc_reg[63:31] - {1'b0, dvs_reg};

    logic [32:0] mul_sum;
    assign mul_sum = {1'b0, acc_reg[63:32]} + {1'b0, dvs_reg};

    logic [63:0] prod;
    assign prod = neg_res_reg ? (64'd0 - acc_reg) : acc_reg;

    assign out_busy = ovalid_reg && !m_axis_tready;

    always_comb
    begin
        logic [31:0] v;
        logic w, c, br, slt, sltu;
        logic [31:0] np, op2, q, r;
        state_next = state_reg;
        clr_next = clr_reg;
        ir_next = ir_reg;
        pc_next = pc_reg;
        out_next = out_reg;
        cnt_next = cnt_reg;
        phase_next = phase_reg;
        acc_next = acc_reg;
        dd_next = dd_reg;
        val_next = val_reg;
        npc_next = npc_reg;
        wr_next = wr_reg;
        br_next = br_reg;
        ad_next = ad_reg;
        neg_res_next = neg_res_reg;
        dvs_next = dvs_reg;
        rfv_next = rfv_reg;
        rf_we = 1'b0;
        rf_wa = rd;
        rf_wd = val_reg;
        dm_we = 1'b0;
        dm_wa = wa0;
        dm_wd = 32'd0;
        dm_ra = wa0;
        // While idle the reads follow the input word, afterwards they hold
        // the operands of the instruction in flight.
        rs1_rd = (state_reg == ST_IDLE) ? s_axis_tdata[19:15] : ir_reg[19:15];
        rs2_rd = (state_reg == ST_IDLE) ? s_axis_tdata[24:20] : ir_reg[24:20];
        s_axis_tready = (state_reg == ST_IDLE);
        v = 32'd0; w = 1'b0; c = 1'b0; br = 1'b0;
        np = pc_reg + 32'd4;
        op2 = (op == OP_REG) ? b : iimm;
        slt = ($signed(a) < $signed(op2));
        sltu = (a < op2);
        q = 32'd0; r = 32'd0;

        case (state_reg)
            ST_CLEAR:
            begin
                dm_we = 1'b1;
                dm_wa = clr_reg[WORD_AW-1:0];
                clr_next = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_W'(MEM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ir_next = s_axis_tdata;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Register reads have landed in ra_q/rb_q.
                ad_next = MEM_AW'(a + ((op == OP_STORE) ? simm : iimm));
                phase_next = 1'b0;
                cnt_next = 6'd0;
                case (op)
                    OP_LOAD: begin w = (f3 != 3'd3 && f3 < 3'd6); end
                    OP_STORE: ;
                    OP_IMM, OP_REG:
                    begin
                        w = 1'b1;
                        case (f3)
                            3'd0:
                            begin
                                if (op == OP_IMM) v = a + op2;
                                else if (f7 == F7_BASE) v = a + op2;
                                else if (f7 == F7_ALT) v = a - op2;
                                else w = 1'b0;
                            end
                            3'd1: v = a << op2[4:0];
                            3'd2: v = {31'd0, slt};
                            3'd3: v = {31'd0, sltu};
                            3'd4: v = a ^ op2;
                            3'd5:
                            begin
                                if (f7 == F7_BASE) v = a >> op2[4:0];
                                else if (f7 == F7_ALT) v = 32'($signed(a) >>> op2[4:0]);
                                else w = 1'b0;
                            end
                            3'd6: v = a | op2;
                            default: v = a & op2;
                        endcase
                    end
                    OP_BRANCH:
                    begin
                        case (f3)
                            3'd0: c = (a == b);
                            3'd1: c = (a != b);
                            3'd4: c = ($signed(a) < $signed(b));
                            3'd5: c = !($signed(a) < $signed(b));
                            3'd6: c = (a < b);
                            3'd7: c = (a >= b);
                            default: c = 1'b0;
                        endcase
                        if (c)
                        begin
                            np = pc_reg + bimm;
                            br = 1'b1;
                        end
                    end
                    OP_JAL: begin w = 1'b1; v = pc_reg + 32'd4; np = pc_reg + jimm; br = 1'b1; end
                    OP_JALR:
                    begin
                        w = 1'b1; v = pc_reg + 32'd4;
                        np = (a + iimm) & 32'hfffffffe; br = 1'b1;
                    end
                    OP_LUI: begin w = 1'b1; v = uimm; end
                    OP_AUIPC: begin w = 1'b1; v = pc_reg + uimm; end
                    default: ;
                endcase
                val_next = v;
                wr_next = w;
                npc_next = np;
                br_next = br;
                if (op == OP_REG && f7[0])
                begin
                    wr_next = 1'b1;
                    state_next = ST_MDIV;
                    dvs_next = abs_b;
                    acc_next = {32'd0, abs_a};
                    neg_res_next = a_neg ^ b_neg;
                    dd_next = a;
                end
                else if (op == OP_LOAD || op == OP_STORE)
                begin
                    state_next = ST_MEM;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_MDIV:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (!f3[2])
                begin
                    // Shift-add: multiplier in acc low half, product builds high.
                    acc_next = acc_reg[0] ? {mul_sum, acc_reg[31:1]}
                                          : {1'b0, acc_reg[63:32], acc_reg[31:1]};
                end
                else
                begin
                    // Restoring division: remainder in high half, quotient in low.
                    if (!rem_try[32])
                    begin
                        acc_next = {rem_try[31:0], acc_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = {acc_reg[62:0], 1'b0};
                    end
                end
                if (cnt_reg == 6'd31)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_MEM:
            begin
                // phase 0: read first word, phase 1: read second, writes follow reads.
                dm_ra = phase_reg ? wa1 : wa0;
                if (cnt_reg[0] == 1'b0)
                begin
                    cnt_next[0] = 1'b1;
                end
                else
                begin
                    cnt_next[0] = 1'b0;
                    if (!phase_reg)
                    begin
                        acc_next[31:0] = dm_q;
                    end
                    if (op == OP_STORE && f3 <= 3'd2)
                    begin
                        dm_we = 1'b1;
                        dm_wa = phase_reg ? wa1 : wa0;
                        dm_wd = phase_reg
                            ? ((dm_q & ~smask_sh[63:32]) | (sdata_sh[63:32] & smask_sh[63:32]))
                            : ((dm_q & ~smask_sh[31:0]) | (sdata_sh[31:0] & smask_sh[31:0]));
                    end
                    if (!phase_reg && lane_hi > 7'd4)
                    begin
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        if (phase_reg) dd_next = dm_q;
                        else dd_next = 32'd0;
                        state_next = ST_OUT;
                        phase_next = 1'b0;
                    end
                end
            end
            ST_OUT:
            begin
                w = wr_reg;
                v = val_reg;
                if (op == OP_REG && f7[0])
                begin
                    if (!f3[2])
                    begin
                        v = (f3 == F3_MUL) ? prod[31:0] : prod[63:32];
                    end
                    else
                    begin
                        q = neg_res_reg ? (32'd0 - acc_reg[31:0]) : acc_reg[31:0];
                        r = dd_reg[31] && (f3 == F3_REM) ? (32'd0 - acc_reg[63:32])
                                                          : acc_reg[63:32];
                        if (dvs_reg == 32'd0)
                        begin
                            q = 32'hffffffff;
                            r = dd_reg;
                        end
                        v = (f3 == F3_DIV || f3 == F3_DIVU) ? q : r;
                    end
                end
                else if (op == OP_LOAD)
                begin
                    r = 32'(ld_cat >> {boff, 3'b000});
                    case (f3)
                        3'd0: v = {{24{r[7]}}, r[7:0]};
                        3'd1: v = {{16{r[15]}}, r[15:0]};
                        3'd4: v = {24'd0, r[7:0]};
                        3'd5: v = {16'd0, r[15:0]};
                        default: v = r;
                    endcase
                end
                if (!w || rd == 5'd0)
                begin
                    w = 1'b0;
                    v = 32'd0;
                end
                if (!out_busy)
                begin
                    rf_we = w;
                    rf_wd = v;
                    if (w) rfv_next[rd] = 1'b1;
                    out_next = {7'd0, ir_reg[31:20] == 12'd1 && op == OP_SYSTEM,
                                ir_reg[31:20] == 12'd0 && op == OP_SYSTEM,
                                br_reg, npc_reg, v, w ? rd : 5'd0, w};
                    pc_next = npc_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (ovalid_reg && m_axis_tready) ovalid_next = 1'b0;
        if (state_reg == ST_OUT && !out_busy) ovalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            pc_reg <= 32'd0;
            ovalid_reg <= 1'b0;
            rfv_reg <= 32'd0;
            cnt_reg <= 6'd0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            pc_reg <= pc_next;
            ovalid_reg <= ovalid_next;
            rfv_reg <= rfv_next;
            cnt_reg <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ir_reg <= ir_next;
        out_reg <= out_next;
        acc_reg <= acc_next;
        dd_reg <= dd_next;
        val_reg <= val_next;
        npc_reg <= npc_next;
        wr_reg <= wr_next;
        br_reg <= br_next;
        ad_reg <= ad_next;
        neg_res_reg <= neg_res_next;
        dvs_reg <= dvs_next;
        rs1v_reg <= rfv_next[rs1_rd];
        rs2v_reg <= rfv_next[rs2_rd];
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = out_reg;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !s_axis_tready)
        else $error("input accepted during memory clear");
    a_x0_never_written: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[5:1] != 5'd0)
        else $error("write to x0 reported");
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire
